// ===== rtl/metr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package metr_pkg;

    // Register reset values
    localparam logic [31:0] MAX_DELTA_RST = 32'd60000000;
    localparam logic [31:0] MAX_LEAD_RST  = 32'd100000;
    localparam logic [31:0] MAX_LAG_RST   = 32'd2000000;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DELTA = 2'd0,
        REG_MAX_LEAD  = 2'd1,
        REG_MAX_LAG   = 2'd2,
        REG_UNUSED    = 2'd3
    } metr_reg_idx_t;

    typedef enum logic {
        OP_MAP     = 1'b0,
        OP_RESTART = 1'b1
    } metr_op_t;

    typedef enum logic [1:0] {
        SRC_INITIAL = 2'd0,
        SRC_DELTA   = 2'd1,
        SRC_INVALID = 2'd2,
        SRC_DISCONT = 2'd3
    } metr_src_t;

    typedef struct packed {
        logic [31:0] max_delta_us;
        logic [31:0] max_lead_us;
        logic [31:0] max_lag_us;
    } metr_cfg_t;

    typedef struct packed {
        logic signed [63:0] event_time_us;
        metr_src_t          time_source;
    } metr_res_t;

endpackage

`default_nettype wire

// ===== rtl/metr_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-pass timestamp decision for one map word.
module metr_calc (
    input  wire logic               started,
    input  wire logic signed [63:0] last_event_us,
    input  wire logic [31:0]        delta_us,
    input  wire logic               delta_bad,
    input  wire logic signed [63:0] arrival_us,
    input  wire metr_pkg::metr_cfg_t cfg,
    output metr_pkg::metr_res_t     res
);
    import metr_pkg::*;

    logic [64:0]        sum_w;
    logic               sum_ovf;
    logic signed [63:0] cand;
    logic [64:0]        lag_diff;
    logic [64:0]        lead_diff;
    logic               cand_behind;
    logic               lag_ok;
    logic               lead_ok;
    logic               window_ok;
    logic               delta_ok;
    logic signed [63:0] fallback;

    // Delta is non-negative, so only positive overflow is possible.
    assign sum_w   = {last_event_us[63], last_event_us} + {33'b0, delta_us};
    assign sum_ovf = sum_w[64] != sum_w[63];
    assign cand    = sum_w[63:0];

    assign lag_diff  = {arrival_us[63], arrival_us} - {cand[63], cand};
    assign lead_diff = {cand[63], cand} - {arrival_us[63], arrival_us};

    assign cand_behind = !lag_diff[64];
    assign lag_ok  = (lag_diff[64:32] == 33'b0) && (lag_diff[31:0] <= cfg.max_lag_us);
    assign lead_ok = (lead_diff[64:32] == 33'b0) && (lead_diff[31:0] <= cfg.max_lead_us);
    assign window_ok = cand_behind ? lag_ok : lead_ok;

    assign delta_ok = !delta_bad && (delta_us <= cfg.max_delta_us);

    // Timeline never moves backward on fallback.
    assign fallback = (arrival_us > last_event_us) ? arrival_us : last_event_us;

    always_comb
    begin
        priority if (!started)
        begin
            res.event_time_us = arrival_us;
            res.time_source   = SRC_INITIAL;
        end
        else if (!delta_ok)
        begin
            res.event_time_us = fallback;
            res.time_source   = SRC_INVALID;
        end
        else if (!sum_ovf && window_ok)
        begin
            res.event_time_us = cand;
            res.time_source   = SRC_DELTA;
        end
        else
        begin
            res.event_time_us = fallback;
            res.time_source   = SRC_DISCONT;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midi_event_timestamp_rebuilder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// MIDI event timestamp rebuilder. Each input word carries a driver delta
// (integer microseconds, plus a bad flag) and the host arrival time; each map
// word yields one output word holding the rebuilt timestamp and a source code
// (initial arrival, driver delta, invalid delta, discontinuity). A restart
// word clears the epoch and yields no output. Timing: an input word is
// registered, then decided combinationally and written to the output register;
// one word can be taken every cycle unless in_stall holds. The rate is
// set by the last-event feedback loop: one 65-bit add, two 65-bit subtracts
// and a few compares between the state register and itself. in_stall rises
// only while the input register holds a map word and the output register is
// full and stalled; a restart word never waits on the output side.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect on the next
// edge and must only be made while the block is idle; index 3 is ignored.
module midi_event_timestamp_rebuilder_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [metr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            opcode,
    input  wire logic [31:0]                     delta_us,
    input  wire logic                            delta_bad,
    input  wire logic signed [63:0]              arrival_us,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [63:0]                   event_time_us,
    output logic [1:0]                           time_source
);
    import metr_pkg::*;

    // configuration registers
    metr_cfg_t          cfg_reg;

    // input register
    logic               s1_valid_reg;
    logic               s1_opcode_reg;
    logic [31:0]        s1_delta_reg;
    logic               s1_bad_reg;
    logic signed [63:0] s1_arrival_reg;

    // timeline state
    logic               started_reg;
    logic               started_next;
    logic signed [63:0] last_event_reg;
    logic signed [63:0] last_event_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    metr_res_t          out_res_reg;

    metr_res_t          calc_res;
    logic               out_free;
    logic               s1_restart;
    logic               s1_fire;
    logic               s1_fire_map;
    logic               in_fire;

    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_restart  = s1_opcode_reg == OP_RESTART;
    assign s1_fire     = s1_valid_reg && (s1_restart || out_free);
    assign s1_fire_map = s1_fire && !s1_restart;

    // input register is free when empty or draining this cycle
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_delta_us <= MAX_DELTA_RST;
            cfg_reg.max_lead_us  <= MAX_LEAD_RST;
            cfg_reg.max_lag_us   <= MAX_LAG_RST;
        end
        else if (cfg_we)
        begin
            unique case (metr_reg_idx_t'(cfg_index))
                REG_MAX_DELTA: cfg_reg.max_delta_us <= cfg_data;
                REG_MAX_LEAD:  cfg_reg.max_lead_us  <= cfg_data;
                REG_MAX_LAG:   cfg_reg.max_lag_us   <= cfg_data;
                REG_UNUSED:    ;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg  <= opcode;
            s1_delta_reg   <= delta_us;
            s1_bad_reg     <= delta_bad;
            s1_arrival_reg <= arrival_us;
        end
    end

    // ---------------------------------------------------------------
    // decision
    // ---------------------------------------------------------------
    metr_calc u_calc (
        .started       (started_reg),
        .last_event_us (last_event_reg),
        .delta_us      (s1_delta_reg),
        .delta_bad     (s1_bad_reg),
        .arrival_us    (s1_arrival_reg),
        .cfg           (cfg_reg),
        .res           (calc_res)
    );

    always_comb
    begin
        started_next    = started_reg;
        last_event_next = last_event_reg;
        if (s1_fire)
        begin
            if (s1_restart)
            begin
                started_next    = 1'b0;
                last_event_next = '0;
            end
            else
            begin
                started_next    = 1'b1;
                last_event_next = calc_res.event_time_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            last_event_reg <= '0;
        end
        else
        begin
            started_reg    <= started_next;
            last_event_reg <= last_event_next;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire_map)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire_map)
        begin
            out_res_reg <= calc_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_time_us = out_res_reg.event_time_us;
    assign time_source   = out_res_reg.time_source;

`ifndef SYNTHESIS
    // a map word leaves the timeline at the value it reports
    a_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire_map |=> started_reg && (last_event_reg == out_res_reg.event_time_us))
        else $error("last event time differs from reported time");

    // restart clears the epoch
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_restart) |=> !started_reg && (last_event_reg == 64'sd0))
        else $error("restart did not clear timeline");

    // timeline is non-decreasing except on initial or restart
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire_map && started_reg) |=> (last_event_reg >= $past(last_event_reg)))
        else $error("timeline moved backward");

    // stall is only raised with a word held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && !s1_restart)
        else $error("input stalled with nothing held");

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !s1_fire_map)
        else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire
